### rtl/relevance_ranked_hypothesis_table_defines.svh
// assertion macros for the hypothesis table
`ifndef RELEVANCE_RANKED_HYPOTHESIS_TABLE_DEFINES_SVH
`define RELEVANCE_RANKED_HYPOTHESIS_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RRHT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RRHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RRHT_ASSERT_IMP(label, ante, cons)
`define RRHT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/rrht_pkg.sv
// types and constants of the hypothesis table
`default_nettype none
package rrht_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_OFFER = 2'd1;
  localparam logic [1:0] OP_EMIT  = 2'd2;
  localparam logic [3:0] TYPE_RUNUP = 4'd1;
  localparam logic [3:0] TYPE_RUNUP_BRAKING = 4'd2;
  localparam logic [3:0] TYPE_PASS = 4'd6;
  localparam logic [3:0] TYPE_CUTIN = 4'd7;
  localparam logic [15:0] PROB_THRESHOLD_RESET = 16'd6554;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_MUL1, ST_MUL2, ST_DIV, ST_SCAN, ST_DECIDE,
    ST_SORT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear_start;
    logic load;
    logic mul2;
    logic div_start;
    logic scan_start;
    logic scan_step;
    logic write;
    logic sort_start;
    logic sort_step;
    logic emit_start;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic obj_bad;
    logic div_done;
    logic scan_done;
    logic sort_done;
    logic emit_last;
    logic clear_done;
  } status_t;

  function automatic logic [15:0] type_weight(input logic [3:0] t);
    case (t)
      4'd1, 4'd2, 4'd11: type_weight = 16'd10000;
      4'd3: type_weight = 16'd8000;
      4'd4: type_weight = 16'd3000;
      4'd5: type_weight = 16'd7500;
      4'd6: type_weight = 16'd1000;
      4'd7: type_weight = 16'd5000;
      4'd8, 4'd10, 4'd13: type_weight = 16'd20000;
      4'd9: type_weight = 16'd40000;
      4'd12: type_weight = 16'd15000;
      default: type_weight = 16'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

### rtl/rrht_ctrl.sv
// controller state machine of the hypothesis table
`default_nettype none
`include "relevance_ranked_hypothesis_table_defines.svh"
module rrht_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire rrht_pkg::status_t status,
  output rrht_pkg::cmd_t cmd
);
  rrht_pkg::state_t state, state_next;
  logic take;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrht_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rrht_pkg::ST_CLEAR: if (status.clear_done) state_next = rrht_pkg::ST_IDLE;
      rrht_pkg::ST_IDLE: begin
        if (take) begin
          case (opcode)
            rrht_pkg::OP_CLEAR: state_next = rrht_pkg::ST_CLEAR;
            rrht_pkg::OP_OFFER: state_next = rrht_pkg::ST_MUL1;
            rrht_pkg::OP_EMIT: state_next = rrht_pkg::ST_SORT;
            default: state_next = rrht_pkg::ST_IDLE;
          endcase
        end
      end
      rrht_pkg::ST_MUL1: begin
        state_next = status.obj_bad ? rrht_pkg::ST_IDLE : rrht_pkg::ST_MUL2;
      end
      rrht_pkg::ST_MUL2: state_next = rrht_pkg::ST_DIV;
      rrht_pkg::ST_DIV: if (status.div_done) state_next = rrht_pkg::ST_SCAN;
      rrht_pkg::ST_SCAN: if (status.scan_done) state_next = rrht_pkg::ST_DECIDE;
      rrht_pkg::ST_DECIDE: state_next = rrht_pkg::ST_IDLE;
      rrht_pkg::ST_SORT: if (status.sort_done) state_next = rrht_pkg::ST_EMIT;
      rrht_pkg::ST_EMIT: begin
        if (out_free && status.emit_last) state_next = rrht_pkg::ST_IDLE;
      end
      default: state_next = rrht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == rrht_pkg::ST_IDLE) && !out_valid;
    cmd = '0;
    case (state)
      rrht_pkg::ST_IDLE: begin
        cmd.load = take;
        cmd.clear_start = take && (opcode == rrht_pkg::OP_CLEAR);
        cmd.sort_start = take && (opcode == rrht_pkg::OP_EMIT);
      end
      rrht_pkg::ST_MUL1: begin
        cmd.mul2 = 1'b1;
      end
      rrht_pkg::ST_MUL2: cmd.div_start = 1'b1;
      rrht_pkg::ST_DIV: cmd.scan_start = status.div_done;
      rrht_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      rrht_pkg::ST_DECIDE: cmd.write = 1'b1;
      rrht_pkg::ST_SORT: begin
        cmd.sort_step = !status.sort_done;
        cmd.emit_start = status.sort_done;
      end
      rrht_pkg::ST_EMIT: cmd.emit_step = out_free;
      default: cmd = '0;
    endcase
  end

  `RRHT_ASSERT_IMP(a_ready_idle, in_ready, state == rrht_pkg::ST_IDLE)
  `RRHT_ASSERT_NEXT(a_offer_goes_mul, take && opcode == rrht_pkg::OP_OFFER,
    state == rrht_pkg::ST_MUL1)
  `RRHT_ASSERT_IMP(a_write_once, cmd.write, state == rrht_pkg::ST_DECIDE && !in_ready)
endmodule
`default_nettype wire

### rtl/rrht_datapath.sv
// table storage, relevance arithmetic, scan and sort of the hypothesis table
`default_nettype none
`include "relevance_ranked_hypothesis_table_defines.svh"
module rrht_datapath #(
  parameter int TABLE_DEPTH = 8,
  parameter int OBJECT_COUNT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire rrht_pkg::cmd_t cmd,
  output rrht_pkg::status_t status,
  input  wire logic [15:0] prob_threshold,
  input  wire logic [3:0] hyp_type,
  input  wire logic [5:0] object_ref,
  input  wire logic [15:0] probability,
  input  wire logic [6:0] object_quality,
  input  wire logic signed [15:0] needed_decel,
  input  wire logic [15:0] lifetime,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [3:0] out_type,
  output logic [5:0] out_object,
  output logic [6:0] out_prob_percent,
  output logic signed [31:0] out_relevance,
  output logic [15:0] out_lifetime,
  output logic out_filled,
  output logic out_last
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [30:0] RECIP_100 = 31'd1374389535;

  logic [3:0] slot_type [TABLE_DEPTH];
  logic [5:0] slot_object [TABLE_DEPTH];
  logic [15:0] slot_prob [TABLE_DEPTH];
  logic signed [31:0] slot_relevance [TABLE_DEPTH];
  logic [15:0] slot_lifetime [TABLE_DEPTH];
  logic [IW-1:0] order [TABLE_DEPTH];
  logic [CW-1:0] entry_count;

  logic [3:0] r_type;
  logic [5:0] r_obj;
  logic [15:0] r_prob;
  logic [6:0] r_qual;
  logic signed [15:0] r_decel;
  logic [15:0] r_life;
  logic [31:0] prod1;
  logic [42:0] num;
  logic [60:0] quot_prod;
  logic quot_ready;
  logic signed [31:0] rel;

  logic [IW-1:0] scan_idx;
  logic [IW-1:0] min_idx;
  logic drop;
  logic scan_busy;
  logic [IW-1:0] sa, sb;
  logic sort_busy;
  logic [IW-1:0] emit_idx;
  logic [IW-1:0] clr_idx;

  logic [6:0] qual_sat;
  logic [CW-1:0] n_used;
  logic kind;
  logic [3:0] st;
  logic [IW-1:0] oa, ob;
  logic [IW-1:0] src;
  logic [22:0] pct;
  logic [IW-1:0] last_idx;

  assign last_idx = IW'(TABLE_DEPTH - 1);
  assign n_used = entry_count;
  assign qual_sat = (object_quality > 7'd100) ? 7'd100 : object_quality;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_type <= hyp_type;
      r_obj <= object_ref;
      r_prob <= probability;
      r_qual <= qual_sat;
      r_decel <= needed_decel;
      r_life <= lifetime;
      prod1 <= 32'(rrht_pkg::type_weight(hyp_type)) * 32'(probability);
    end
    if (cmd.mul2) begin
      num <= 43'(prod1) * 43'(r_qual) + 43'd12800;
    end
  end

  // divide by 25600: drop 8 bits, then reciprocal multiply by 1/100
  always_ff @(posedge clk) begin
    if (cmd.div_start) quot_prod <= 61'(num[37:8]) * 61'(RECIP_100);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      quot_ready <= 1'b0;
    end else begin
      quot_ready <= cmd.div_start;
    end
  end
  assign status.div_done = quot_ready;
  assign rel = 32'(quot_prod[60:37]) - 32'(r_decel);
  assign status.obj_bad = 32'(r_obj) >= 32'(OBJECT_COUNT);

  // suppression and minimum scan, one slot per cycle
  assign st = slot_type[scan_idx];
  assign kind = (st == rrht_pkg::TYPE_RUNUP) || (st == rrht_pkg::TYPE_RUNUP_BRAKING) ||
                (r_type == rrht_pkg::TYPE_PASS && st == rrht_pkg::TYPE_CUTIN);
  assign status.scan_done = scan_busy && (scan_idx == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_busy <= 1'b1;
      scan_idx <= '0;
      min_idx <= '0;
      drop <= 1'b0;
    end else if (cmd.scan_step) begin
      if (CW'(scan_idx) < n_used && slot_object[scan_idx] == r_obj && kind &&
          slot_prob[scan_idx] > prob_threshold &&
          (r_type == rrht_pkg::TYPE_PASS || r_type == rrht_pkg::TYPE_CUTIN)) begin
        drop <= 1'b1;
      end
      if (slot_relevance[scan_idx] < slot_relevance[min_idx]) min_idx <= scan_idx;
      if (scan_idx == last_idx) scan_busy <= 1'b0;
      else scan_idx <= scan_idx + 1'b1;
    end
  end

  // table writes: clearing sweep, insertion, and replacement of the least relevant entry
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      clr_idx <= '0;
      entry_count <= '0;
    end else if (!status.clear_done) begin
      slot_type[clr_idx] <= '0;
      slot_object[clr_idx] <= '0;
      slot_prob[clr_idx] <= '0;
      slot_relevance[clr_idx] <= '0;
      slot_lifetime[clr_idx] <= '0;
      clr_idx <= clr_idx + 1'b1;
    end else if (cmd.write && !drop) begin
      if (n_used < CW'(TABLE_DEPTH)) begin
        slot_type[IW'(n_used)] <= r_type;
        slot_object[IW'(n_used)] <= r_obj;
        slot_prob[IW'(n_used)] <= r_prob;
        slot_relevance[IW'(n_used)] <= rel;
        slot_lifetime[IW'(n_used)] <= r_life;
        entry_count <= entry_count + 1'b1;
      end else if (slot_relevance[min_idx] < rel) begin
        slot_type[min_idx] <= r_type;
        slot_object[min_idx] <= r_obj;
        slot_prob[min_idx] <= r_prob;
        slot_relevance[min_idx] <= rel;
        slot_lifetime[min_idx] <= r_life;
      end
    end
  end
  logic clr_run;
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) clr_run <= 1'b1;
    else if (clr_idx == last_idx) clr_run <= 1'b0;
  end
  assign status.clear_done = !clr_run;

  // exchange sort over the order list, one compare per cycle
  assign oa = order[sa];
  assign ob = order[sb];
  assign status.sort_done = !sort_busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_busy <= 1'b0;
    end else if (cmd.sort_start) begin
      for (int i = 0; i < TABLE_DEPTH; i++) order[i] <= IW'(i);
      sa <= '0;
      sb <= IW'(1);
      sort_busy <= n_used > CW'(1);
    end else if (cmd.sort_step && sort_busy) begin
      if (slot_relevance[oa] < slot_relevance[ob]) begin
        order[sa] <= ob;
        order[sb] <= oa;
      end
      if (CW'(sb) + 1'b1 < n_used) begin
        sb <= sb + 1'b1;
      end else if (CW'(sa) + 2'd2 < n_used) begin
        sa <= sa + 1'b1;
        sb <= sa + 2'd2;
      end else begin
        sort_busy <= 1'b0;
      end
    end
  end

  // result register
  assign src = order[emit_idx];
  assign pct = 23'(slot_prob[src]) * 23'd100 + 23'd32768;
  assign status.emit_last = emit_idx == last_idx;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      emit_idx <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.emit_start) begin
        emit_idx <= '0;
      end else if (cmd.emit_step) begin
        out_valid <= 1'b1;
        emit_idx <= emit_idx + 1'b1;
        if (CW'(emit_idx) < n_used) begin
          out_type <= slot_type[src];
          out_object <= slot_object[src];
          out_prob_percent <= pct[22:16];
          out_relevance <= slot_relevance[src];
          out_lifetime <= slot_lifetime[src];
          out_filled <= 1'b1;
        end else begin
          out_type <= '0;
          out_object <= '0;
          out_prob_percent <= '0;
          out_relevance <= '0;
          out_lifetime <= '0;
          out_filled <= 1'b0;
        end
        out_last <= emit_idx == last_idx;
      end
    end
  end

  `RRHT_ASSERT_IMP(a_count_bound, 1'b1, entry_count <= CW'(TABLE_DEPTH))
  `RRHT_ASSERT_NEXT(a_clear_empties, cmd.clear_start, entry_count == '0)
  `RRHT_ASSERT_IMP(a_empty_zero, out_valid && !out_filled, out_relevance == 32'sd0)
endmodule
`default_nettype wire

### rtl/relevance_ranked_hypothesis_table.sv
// top level of the relevance ranked hypothesis table
// clear: sweep over all slots; offer: two multiplies, divide, scan of all slots, decide
// emit: exchange sort of the n used entries, then one result per cycle while accepted
// one item at a time; ready is low while an item is at work
// reset: synchronous, runs a clearing pass over all slots, threshold back to 6554
`default_nettype none
module relevance_ranked_hypothesis_table #(
  parameter int TABLE_DEPTH = 8,
  parameter int OBJECT_COUNT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [3:0] hyp_type,
  input  wire logic [5:0] object_ref,
  input  wire logic [15:0] probability,
  input  wire logic [6:0] object_quality,
  input  wire logic signed [15:0] needed_decel,
  input  wire logic [15:0] lifetime,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [3:0] out_type,
  output logic [5:0] out_object,
  output logic [6:0] out_prob_percent,
  output logic signed [31:0] out_relevance,
  output logic [15:0] out_lifetime,
  output logic out_filled,
  output logic out_last
);
  rrht_pkg::cmd_t cmd;
  rrht_pkg::status_t status;
  logic [15:0] prob_threshold;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      prob_threshold <= rrht_pkg::PROB_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      prob_threshold <= cfg_data;
    end
  end

  rrht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  rrht_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .OBJECT_COUNT(OBJECT_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .prob_threshold(prob_threshold),
    .hyp_type(hyp_type), .object_ref(object_ref), .probability(probability),
    .object_quality(object_quality), .needed_decel(needed_decel), .lifetime(lifetime),
    .out_valid(out_valid), .out_ready(out_ready), .out_type(out_type),
    .out_object(out_object), .out_prob_percent(out_prob_percent),
    .out_relevance(out_relevance), .out_lifetime(out_lifetime),
    .out_filled(out_filled), .out_last(out_last)
  );
endmodule
`default_nettype wire
